// File: src/dq_pkg.sv
// Shared types and codes for the double-ended queue core.
// Request and response payload structs, command and status codes.
// No dependencies.
`timescale 1ns / 1ps

package dq_pkg;

    localparam int DataWidth = 32;

    // Command codes
    localparam logic [2:0] CMD_PUSH_BACK  = 3'd0;
    localparam logic [2:0] CMD_PUSH_FRONT = 3'd1;
    localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
    localparam logic [2:0] CMD_POP_BACK   = 3'd3;
    localparam logic [2:0] CMD_QUERY      = 3'd4;

    // Status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_POP_EMPTY = 2'd1;
    localparam logic [1:0] ST_PUSH_FULL = 2'd2;

    typedef struct packed {
        logic [2:0]                  command;
        logic signed [DataWidth-1:0] push_value;
    } t_dq_req;

    typedef struct packed {
        logic [1:0]                  status;
        logic signed [DataWidth-1:0] front_value;
        logic signed [DataWidth-1:0] back_value;
        logic [4:0]                  occupancy;
        logic                        is_empty;
    } t_dq_rsp;

endpackage

// File: src/double_ended_queue_core.sv
// Bounded double-ended queue core: ring of DEPTH signed 32-bit entries.
// A request accepted in S_IDLE is read back from the RAM in S_READ; its result is strobed in S_DONE.
// busy stays high through S_READ and S_DONE: a new request is taken only once
// the write / read / report sequence around the single entry RAM is through.
// Reset (synchronous, active low) empties the queue; the RAM keeps its contents.
// The receiver cannot stall: each result is shown for one cycle only.
`timescale 1ns / 1ps

module double_ended_queue_core
    import dq_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    output logic    busy,
    input  t_dq_req i_req,
    output logic    o_valid,
    output t_dq_rsp o_rsp
);

    localparam int PW = $clog2(DEPTH);      // pointer width
    localparam int CW = $clog2(DEPTH + 1);  // count width, holds DEPTH itself

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state          r_state, n_state;
    logic [PW-1:0]   r_head, n_head;
    logic [PW-1:0]   r_tail, n_tail;
    logic [CW-1:0]   r_count, n_count;
    logic [1:0]      r_status, n_status;

    // RAM ports: write side driven at the accept edge, read side in S_READ
    logic            w_we;
    logic [PW-1:0]   w_waddr;
    logic            w_re;
    logic signed [DataWidth-1:0] w_front, w_back;

    logic            w_accept;
    logic            w_full;
    logic            w_empty;
    logic [PW-1:0]   w_head_prev, w_head_next;
    logic [PW-1:0]   w_tail_prev, w_tail_next;

    function automatic logic [PW-1:0] ring_next(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [PW-1:0] ring_prev(input logic [PW-1:0] p);
        return (p == '0) ? PW'(DEPTH - 1) : p - 1'b1;
    endfunction

    assign busy     = (r_state != S_IDLE);
    assign w_accept = start && !busy;
    assign w_full   = (r_count == CW'(DEPTH));
    assign w_empty  = (r_count == '0);

    assign w_head_prev = ring_prev(r_head);
    assign w_head_next = ring_next(r_head);
    assign w_tail_prev = ring_prev(r_tail);
    assign w_tail_next = ring_next(r_tail);

    // Command decode: pointer / count / status update and RAM write at accept, then S_READ and S_DONE.
    always_comb begin
        n_state  = r_state;
        n_head   = r_head;
        n_tail   = r_tail;
        n_count  = r_count;
        n_status = r_status;
        w_we     = 1'b0;
        w_waddr  = r_tail;
        w_re     = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state  = S_READ;
                    n_status = ST_OK;
                    unique case (i_req.command)
                        CMD_PUSH_BACK: begin
                            if (w_full) begin
                                n_status = ST_PUSH_FULL;
                            end else begin
                                w_we    = 1'b1;
                                w_waddr = r_tail;
                                n_tail  = w_tail_next;
                                n_count = r_count + 1'b1;
                            end
                        end
                        CMD_PUSH_FRONT: begin
                            if (w_full) begin
                                n_status = ST_PUSH_FULL;
                            end else begin
                                w_we    = 1'b1;
                                w_waddr = w_head_prev;
                                n_head  = w_head_prev;
                                n_count = r_count + 1'b1;
                            end
                        end
                        CMD_POP_FRONT: begin
                            if (w_empty) begin
                                n_status = ST_POP_EMPTY;
                            end else begin
                                n_head  = w_head_next;
                                n_count = r_count - 1'b1;
                            end
                        end
                        CMD_POP_BACK: begin
                            if (w_empty) begin
                                n_status = ST_POP_EMPTY;
                            end else begin
                                n_tail  = w_tail_prev;
                                n_count = r_count - 1'b1;
                            end
                        end
                        default: begin
                            // query and unused codes leave pointers and count alone
                        end
                    endcase
                end
            end
            S_READ: begin
                // write landed last edge, so reading now sees it
                w_re    = 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_head   <= '0;
            r_tail   <= '0;
            r_count  <= '0;
            r_status <= ST_OK;
        end else begin
            r_state  <= n_state;
            r_head   <= n_head;
            r_tail   <= n_tail;
            r_count  <= n_count;
            r_status <= n_status;
        end
    end

    dq_ram #(
        .DEPTH (DEPTH),
        .AW    (PW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_waddr   (w_waddr),
        .i_wdata   (i_req.push_value),
        .i_re      (w_re),
        .i_raddr_a (r_head),
        .i_raddr_b (w_tail_prev),
        .o_rdata_a (w_front),
        .o_rdata_b (w_back)
    );

    // Result: pointers and count are stable through S_READ and S_DONE.
    assign o_valid           = (r_state == S_DONE);
    assign o_rsp.status      = r_status;
    assign o_rsp.front_value = w_empty ? -32'sd1 : w_front;
    assign o_rsp.back_value  = w_empty ? -32'sd1 : w_back;
    assign o_rsp.occupancy   = 5'(r_count);
    assign o_rsp.is_empty    = w_empty;

endmodule

// File: src/dq_ram.sv
// Entry store of the queue: one write port, two registered read ports.
// Depends on dq_pkg for the data width.
`timescale 1ns / 1ps

module dq_ram
    import dq_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [AW-1:0]               i_waddr,
    input  logic signed [DataWidth-1:0] i_wdata,
    input  logic                        i_re,
    input  logic [AW-1:0]               i_raddr_a,
    input  logic [AW-1:0]               i_raddr_b,
    output logic signed [DataWidth-1:0] o_rdata_a,
    output logic signed [DataWidth-1:0] o_rdata_b
);

    logic signed [DataWidth-1:0] r_mem [DEPTH];
    logic signed [DataWidth-1:0] r_rdata_a;
    logic signed [DataWidth-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata_a <= r_mem[i_raddr_a];
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule
